[sv/adpf_pkg.sv]
package adpf_pkg;

   // fixed field widths
   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned LEVEL_W  = 12;
   localparam int unsigned FILL_W   = 9;
   localparam int unsigned THRESH_W = 9;
   localparam int unsigned SHIFT_W  = LEVEL_W - SAMPLE_W;

   // defaults for the top level parameters
   localparam int unsigned FIFO_DEPTH_DEF = 256;
   localparam int unsigned FADE_STEPS_DEF = 16;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(128);

   // command codes as they arrive on the stream
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_PUSH  = 2'd1,
      CMD_START = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   // playback modes, coded as reported on the result stream
   typedef enum logic [1:0] {
      MODE_STOPPED  = 2'd0,
      MODE_STARTING = 2'd1,
      MODE_PLAYING  = 2'd2,
      MODE_STOPPING = 2'd3
   } mode_type;

   // decoded operation handed from front to back
   typedef struct packed {
      cmd_type              cmd;
      logic [SAMPLE_W-1:0]  sample;
   } op_type;

endpackage

[sv/audio_dac_playback_fader.sv]
// Playback controller that feeds a 12-bit DAC from a byte sample store. Each
// request transfer carries a command in req_tuser (tick, push, start, stop) and a
// sample in req_tdata; every request gives exactly one response transfer with
// the DAC write flag in rsp_tuser and the converter code, mode, push status
// and fill level in rsp_tdata. The block sustains one transfer per clock
// while the response side does not stall: a two-entry command queue decouples
// the input from a single execute stage that updates all play state once per
// cycle. The response is registered and becomes valid in the cycle after the
// execute stage takes its request from the command queue. The sample store is a
// FIFO_DEPTH x 8 RAM with registered read; its contents are never cleared and
// need no clearing pass. start_threshold resets to 128. The user must write it
// through csr_we/csr_wdata while the block is idle; the block does not check.
module audio_dac_playback_fader #(
   parameter int unsigned FIFO_DEPTH = adpf_pkg::FIFO_DEPTH_DEF,
   parameter int unsigned FADE_STEPS = adpf_pkg::FADE_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_we,
   input  logic [adpf_pkg::THRESH_W-1:0]  csr_wdata,   // start_threshold
   // requests
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] sample
   input  logic [1:0]                     req_tuser,   // [1:0] command
   // responses
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [11:0] dac_value, [13:12] mode,
                                                       // [14] push_accepted, [23:15] fill_level
   output logic                           rsp_tuser    // [0] dac_write
);

   logic             op_valid;
   logic             op_take;
   adpf_pkg::op_type op;

   adpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (op_valid),
      .op_take    (op_take),
      .op          (op)
   );

   adpf_back #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .FADE_STEPS (FADE_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .op_valid   (op_valid),
      .op_take    (op_take),
      .op         (op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[sv/adpf_ram.sv]
module adpf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/adpf_front.sv]
module adpf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [adpf_pkg::SAMPLE_W-1:0]     req_tdata,
   input  logic [1:0]                        req_tuser,
   output logic                              op_valid,
   input  logic                              op_take,
   output adpf_pkg::op_type                  op
);

   adpf_pkg::op_type q_ff [2];
   logic             wr_sel_ff;
   logic             wr_sel_in;
   logic             rd_sel_ff;
   logic             rd_sel_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             accept;
   adpf_pkg::op_type op_dec;

   assign req_tready = (count_ff != 2'd2);
   assign accept     = req_tvalid && req_tready;

   // decode the command, keep the sample only for a push
   always_comb begin
      op_dec.cmd    = adpf_pkg::cmd_type'(req_tuser);
      op_dec.sample = (op_dec.cmd == adpf_pkg::CMD_PUSH) ? req_tdata : '0;
   end

   // two-entry queue toward the back end
   always_comb begin
      wr_sel_in = accept ? ~wr_sel_ff : wr_sel_ff;
      rd_sel_in = op_take ? ~rd_sel_ff : rd_sel_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, op_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_sel_ff <= wr_sel_in;
         rd_sel_ff <= rd_sel_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_sel_ff] <= op_dec;
      end
   end

   assign op_valid = (count_ff != 2'd0);
   assign op       = q_ff[rd_sel_ff];

   // queue occupancy stays within its two entries
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("front queue count out of range");

endmodule

[sv/adpf_back.sv]
module adpf_back #(
   parameter int unsigned FIFO_DEPTH = adpf_pkg::FIFO_DEPTH_DEF,
   parameter int unsigned FADE_STEPS = adpf_pkg::FADE_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [adpf_pkg::THRESH_W-1:0]  csr_wdata,
   input  logic                           op_valid,
   output logic                           op_take,
   input  adpf_pkg::op_type               op,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,
   output logic                           rsp_tuser
);

   localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned CMP_W   = (CNT_W > adpf_pkg::FILL_W) ? CNT_W : adpf_pkg::FILL_W;
   localparam int unsigned LVL_W   = adpf_pkg::LEVEL_W;
   // level / FADE_STEPS as a reciprocal multiply, exact for every 12-bit level
   localparam int unsigned DIV_SHIFT = LVL_W + $clog2(FADE_STEPS);
   localparam int unsigned DIV_MULT  = ((1 << DIV_SHIFT) + FADE_STEPS - 1) / FADE_STEPS;
   localparam int unsigned MUL_W     = LVL_W + 1;
   localparam int unsigned PROD_W    = LVL_W + MUL_W;

   // play state
   adpf_pkg::mode_type         mode_ff;
   adpf_pkg::mode_type         mode_in;
   logic [PTR_W-1:0]           rd_ptr_ff;
   logic [PTR_W-1:0]           rd_ptr_in;
   logic [PTR_W-1:0]           wr_ptr_ff;
   logic [PTR_W-1:0]           wr_ptr_in;
   logic [CNT_W-1:0]           fill_ff;
   logic [CNT_W-1:0]           fill_in;
   logic [LVL_W-1:0]           level_ff;
   logic [LVL_W-1:0]           level_in;
   logic                       level_ram_ff;
   logic                       level_ram_in;
   logic [LVL_W-1:0]           step_ff;
   logic [LVL_W-1:0]           step_in;
   logic [adpf_pkg::THRESH_W-1:0] thresh_ff;

   // result register
   logic                       out_valid_ff;
   logic                       res_write_ff;
   logic                       res_write_in;
   logic [LVL_W-1:0]           res_value_ff;
   logic [LVL_W-1:0]           res_value_in;
   logic                       res_ram_ff;
   logic                       res_ram_in;
   adpf_pkg::mode_type         res_mode_ff;
   logic                       res_acc_ff;
   logic                       res_acc_in;
   logic [adpf_pkg::FILL_W-1:0] res_fill_ff;

   // sample store ports
   logic                          ram_we;
   logic                          ram_re;
   logic [adpf_pkg::SAMPLE_W-1:0] ram_q;

   logic                       fire;
   logic [LVL_W-1:0]           level_eff;
   logic [PROD_W-1:0]          prod;
   logic [LVL_W-1:0]           level_div;
   logic                       has_room;
   logic                       has_data;
   logic                       at_thresh;
   logic [CMP_W-1:0]           fill_cmp;
   logic [CMP_W-1:0]           fill_out_ext;
   logic                       fade_under;
   logic [LVL_W-1:0]           level_faded;

   assign fire    = op_valid && (!out_valid_ff || rsp_tready);
   assign op_take = fire;

   // current level: either the register or the byte last popped from the store
   assign level_eff = level_ram_ff ? {ram_q, {adpf_pkg::SHIFT_W{1'b0}}} : level_ff;
   assign prod      = PROD_W'(level_eff) * PROD_W'(MUL_W'(DIV_MULT));
   assign level_div = LVL_W'(prod >> DIV_SHIFT);

   // fifo and fade conditions
   assign fill_cmp    = CMP_W'(fill_ff);
   assign has_room    = (fill_ff < CNT_W'(FIFO_DEPTH));
   assign has_data    = (fill_ff != '0);
   assign at_thresh   = (fill_cmp >= CMP_W'(thresh_ff));
   assign fade_under  = (step_ff > level_eff);
   assign level_faded = fade_under ? '0 : level_eff - step_ff;

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (op.cmd)
         adpf_pkg::CMD_START: begin
            mode_in = adpf_pkg::MODE_STARTING;
         end
         adpf_pkg::CMD_STOP: begin
            if (mode_ff inside {adpf_pkg::MODE_STARTING, adpf_pkg::MODE_PLAYING}) begin
               mode_in = adpf_pkg::MODE_STOPPING;
            end
         end
         adpf_pkg::CMD_TICK: begin
            case (mode_ff)
               adpf_pkg::MODE_PLAYING: begin
                  if (!has_data) mode_in = adpf_pkg::MODE_STARTING;
               end
               adpf_pkg::MODE_STARTING: begin
                  if (at_thresh) mode_in = adpf_pkg::MODE_PLAYING;
               end
               adpf_pkg::MODE_STOPPING: begin
                  if (fade_under) mode_in = adpf_pkg::MODE_STOPPED;
               end
               default: mode_in = mode_ff;
            endcase
         end
         default: mode_in = mode_ff;
      endcase
   end

   // datapath for one operation
   always_comb begin
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      level_in     = level_ff;
      level_ram_in = level_ram_ff;
      step_in      = step_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      res_write_in = 1'b0;
      res_value_in = '0;
      res_ram_in   = 1'b0;
      res_acc_in   = 1'b0;
      case (op.cmd)
         adpf_pkg::CMD_PUSH: begin
            if (has_room) begin
               ram_we     = fire;
               wr_ptr_in  = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
               fill_in    = fill_ff + 1'b1;
               res_acc_in = 1'b1;
            end
         end
         adpf_pkg::CMD_START: begin
            rd_ptr_in    = '0;
            wr_ptr_in    = '0;
            fill_in      = '0;
            level_in     = '0;
            level_ram_in = 1'b0;
         end
         adpf_pkg::CMD_STOP: begin
            if (mode_ff inside {adpf_pkg::MODE_STARTING, adpf_pkg::MODE_PLAYING}) begin
               step_in = (level_div == '0) ? LVL_W'(1) : level_div;
            end
         end
         adpf_pkg::CMD_TICK: begin
            res_write_in = 1'b1;
            case (mode_ff)
               adpf_pkg::MODE_PLAYING: begin
                  if (has_data) begin
                     ram_re       = fire;
                     rd_ptr_in    = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                  : rd_ptr_ff + 1'b1;
                     fill_in      = fill_ff - 1'b1;
                     level_ram_in = 1'b1;
                     res_ram_in   = 1'b1;
                  end else begin
                     step_in      = level_div;
                     res_write_in = 1'b0;
                  end
               end
               adpf_pkg::MODE_STARTING: begin
                  if (at_thresh) begin
                     res_write_in = 1'b0;
                  end else begin
                     level_in     = level_faded;
                     level_ram_in = 1'b0;
                     res_value_in = level_faded;
                  end
               end
               adpf_pkg::MODE_STOPPING: begin
                  level_in     = level_faded;
                  level_ram_in = 1'b0;
                  res_value_in = level_faded;
               end
               default: res_value_in = '0;
            endcase
         end
         default: res_write_in = 1'b0;
      endcase
   end

   assign fill_out_ext = CMP_W'(fill_in);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= adpf_pkg::MODE_STOPPED;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         level_ff     <= '0;
         level_ram_ff <= 1'b0;
         step_ff      <= '0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         level_ff     <= level_in;
         level_ram_ff <= level_ram_in;
         step_ff      <= step_in;
      end
   end

   // start threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= adpf_pkg::THRESH_RESET;
      end else if (csr_we) begin
         thresh_ff <= csr_wdata;
      end
   end

   // result register, handed on when the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_write_ff <= res_write_in;
         res_value_ff <= res_value_in;
         res_ram_ff   <= res_ram_in;
         res_mode_ff  <= mode_in;
         res_acc_ff   <= res_acc_in;
         res_fill_ff  <= fill_out_ext[adpf_pkg::FILL_W-1:0];
      end
   end

   adpf_ram #(
      .WIDTH (adpf_pkg::SAMPLE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (op.sample),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = res_write_ff;
   assign rsp_tdata  = {res_fill_ff, res_acc_ff, res_mode_ff,
                        res_ram_ff ? {ram_q, {adpf_pkg::SHIFT_W{1'b0}}} : res_value_ff};

   // a pop may only replace the store's read data once the pending result leaves
   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (!out_valid_ff || rsp_tready))
      else $error("sample store read while result still pending");

   // fill count never passes the store depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fill count above store depth");

   // a fade-out always moves by a nonzero step
   a_stop_step: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == adpf_pkg::MODE_STOPPING) |-> (step_ff != '0))
      else $error("stopping with zero fade step");

endmodule

[dv/audio_dac_playback_fader_tb.sv]
`timescale 1ns / 100ps

module audio_dac_playback_fader_tb;

   localparam int unsigned FIFO_DEPTH      = adpf_pkg::FIFO_DEPTH_DEF;
   localparam int unsigned FADE_STEPS      = adpf_pkg::FADE_STEPS_DEF;
   localparam int unsigned PTR_W           = $clog2(FIFO_DEPTH);
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam int unsigned MAX_REPORTS     = 10;

   // one response transfer, split into its fields
   typedef struct packed {
      logic                         wr;
      logic [adpf_pkg::LEVEL_W-1:0] value;
      adpf_pkg::mode_type           mode;
      logic                         accepted;
      logic [adpf_pkg::FILL_W-1:0]  fill;
   } dac_result_type;

   // one line of the directed table: a threshold write or a command
   typedef struct {
      bit                            is_cfg;
      logic [adpf_pkg::THRESH_W-1:0] cfg_val;
      adpf_pkg::cmd_type             cmd;
      logic [adpf_pkg::SAMPLE_W-1:0] smp;
      bit                            typed;
      dac_result_type                res;
   } dir_row_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            csr_we     = 1'b0;
   logic [adpf_pkg::THRESH_W-1:0]   csr_wdata  = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = '0;   // [7:0] sample
   logic [1:0]                      req_tuser  = '0;   // [1:0] command
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [23:0]                     rsp_tdata;         // [11:0] dac_value, [13:12] mode,
                                                       // [14] push_accepted, [23:15] fill_level
   logic                            rsp_tuser;         // [0] dac_write

   // player state as the testbench sees it
   logic [adpf_pkg::SAMPLE_W-1:0]   pl_store [FIFO_DEPTH];
   logic [PTR_W-1:0]                pl_rd = '0;
   logic [PTR_W-1:0]                pl_wr = '0;
   logic [adpf_pkg::FILL_W-1:0]     pl_fill = '0;
   adpf_pkg::mode_type              pl_mode = adpf_pkg::MODE_STOPPED;
   logic [adpf_pkg::LEVEL_W-1:0]    pl_level = '0;
   logic [adpf_pkg::LEVEL_W-1:0]    pl_step = '0;
   logic [adpf_pkg::THRESH_W-1:0]   pl_threshold = adpf_pkg::THRESH_RESET;

   dac_result_type                  dac_results_due [$];
   dir_row_type                     dir_rows [$];

   int                   err_count = 0;
   int                   items_sent = 0;
   int                   rsp_checked = 0;
   int                   refused_pushes = 0;
   int                   dac_writes = 0;
   bit                   hold_off_req = 1'b0;
   bit                   no_idle = 1'b0;

   audio_dac_playback_fader uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // advance the player by one command and return the response it gives
   function automatic dac_result_type play_step(adpf_pkg::cmd_type cmd,
                                                logic [adpf_pkg::SAMPLE_W-1:0] smp);
      dac_result_type r;
      logic [adpf_pkg::LEVEL_W-1:0] s;
      r = '0;
      case (cmd)
         adpf_pkg::CMD_PUSH: begin
            if (pl_fill < FIFO_DEPTH) begin
               pl_store[pl_wr] = smp;
               pl_wr = pl_wr + 1'b1;
               pl_fill = pl_fill + 1'b1;
               r.accepted = 1'b1;
            end else begin
               refused_pushes++;
            end
         end
         adpf_pkg::CMD_START: begin
            pl_rd = '0;
            pl_wr = '0;
            pl_fill = '0;
            pl_level = '0;
            pl_mode = adpf_pkg::MODE_STARTING;
         end
         adpf_pkg::CMD_STOP: begin
            // fade step never below one so the fade always ends
            if (pl_mode == adpf_pkg::MODE_STARTING || pl_mode == adpf_pkg::MODE_PLAYING) begin
               s = adpf_pkg::LEVEL_W'(pl_level / FADE_STEPS);
               pl_step = (s == '0) ? adpf_pkg::LEVEL_W'(1) : s;
               pl_mode = adpf_pkg::MODE_STOPPING;
            end
         end
         default: begin
            case (pl_mode)
               adpf_pkg::MODE_PLAYING: begin
                  if (pl_fill != '0) begin
                     pl_level = adpf_pkg::LEVEL_W'(pl_store[pl_rd]) << adpf_pkg::SHIFT_W;
                     pl_rd = pl_rd + 1'b1;
                     pl_fill = pl_fill - 1'b1;
                     r.wr = 1'b1;
                     r.value = pl_level;
                  end else begin
                     // underrun: fall back and fade from the last level
                     pl_mode = adpf_pkg::MODE_STARTING;
                     pl_step = adpf_pkg::LEVEL_W'(pl_level / FADE_STEPS);
                  end
               end
               adpf_pkg::MODE_STARTING: begin
                  if (pl_fill >= pl_threshold) begin
                     pl_mode = adpf_pkg::MODE_PLAYING;
                  end else begin
                     pl_level = (pl_step > pl_level) ? '0 : pl_level - pl_step;
                     r.wr = 1'b1;
                     r.value = pl_level;
                  end
               end
               adpf_pkg::MODE_STOPPING: begin
                  if (pl_step > pl_level) begin
                     pl_level = '0;
                     pl_mode = adpf_pkg::MODE_STOPPED;
                  end else begin
                     pl_level = pl_level - pl_step;
                  end
                  r.wr = 1'b1;
                  r.value = pl_level;
               end
               default: begin
                  r.wr = 1'b1;
               end
            endcase
         end
      endcase
      r.mode = pl_mode;
      r.fill = pl_fill;
      return r;
   endfunction

   // directed table rows
   function automatic dir_row_type cmd_row(adpf_pkg::cmd_type c,
                                           logic [adpf_pkg::SAMPLE_W-1:0] s);
      dir_row_type d;
      d = '{is_cfg: 1'b0, cfg_val: '0, cmd: c, smp: s, typed: 1'b0, res: '0};
      return d;
   endfunction

   function automatic dir_row_type known_row(adpf_pkg::cmd_type c,
                                             logic [adpf_pkg::SAMPLE_W-1:0] s, logic wr,
                                             logic [adpf_pkg::LEVEL_W-1:0] v,
                                             adpf_pkg::mode_type m, logic acc,
                                             logic [adpf_pkg::FILL_W-1:0] f);
      dir_row_type d;
      d = cmd_row(c, s);
      d.typed = 1'b1;
      d.res = '{wr: wr, value: v, mode: m, accepted: acc, fill: f};
      return d;
   endfunction

   function automatic dir_row_type cfg_row(logic [adpf_pkg::THRESH_W-1:0] v);
      dir_row_type d;
      d = cmd_row(adpf_pkg::CMD_TICK, '0);
      d.is_cfg = 1'b1;
      d.cfg_val = v;
      return d;
   endfunction

   // offer one command, wait for its transfer, queue what it should give
   task automatic send_item(adpf_pkg::cmd_type cmd, logic [adpf_pkg::SAMPLE_W-1:0] smp,
                            bit typed = 1'b0, dac_result_type want = '0);
      dac_result_type pred;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      pred = play_step(cmd, smp);
      dac_results_due.push_back(typed ? want : pred);
      items_sent++;
   endtask

   // stop offering and let every outstanding response come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (dac_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [adpf_pkg::THRESH_W-1:0] v);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      pl_threshold = v;
   endtask

   // a playback session: start, then push bursts, tick runs, stops, restarts and some noise
   task automatic run_session(int n, int push_pct);
      int stop_at;
      int r;
      int k;
      stop_at = items_sent + n;
      send_item(adpf_pkg::CMD_START, 8'($urandom));
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         k = $urandom_range(1, 12);
         if (r < push_pct) begin
            repeat (k) send_item(adpf_pkg::CMD_PUSH, 8'($urandom));
         end else if (r < push_pct + 30) begin
            repeat (k) send_item(adpf_pkg::CMD_TICK, 8'($urandom));
         end else if (r < push_pct + 36) begin
            send_item(adpf_pkg::CMD_STOP, 8'($urandom));
            repeat ($urandom_range(1, 20)) send_item(adpf_pkg::CMD_TICK, 8'($urandom));
         end else if (r < push_pct + 40) begin
            send_item(adpf_pkg::CMD_START, 8'($urandom));
         end else begin
            send_item(adpf_pkg::cmd_type'($urandom_range(0, 3)), 8'($urandom));
         end
      end
   endtask

   // response side: random stalls, one long hold-off on request, none at the end
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            if (!no_idle) repeat ($urandom_range(0, 15)) @(posedge clock);
         end
      end
   end

   // check each response transfer against the oldest one due
   always @(posedge clock) begin : rsp_check
      dac_result_type got;
      dac_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.wr       = rsp_tuser;
         got.value    = rsp_tdata[11:0];
         got.mode     = adpf_pkg::mode_type'(rsp_tdata[13:12]);
         got.accepted = rsp_tdata[14];
         got.fill     = rsp_tdata[23:15];
         if (dac_results_due.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("%0t: response with nothing due: wr %0b value %h mode %0d acc %0b fill %0d",
                        $realtime, got.wr, got.value, got.mode, got.accepted, got.fill);
         end else begin
            want = dac_results_due.pop_front();
            rsp_checked++;
            if (got.wr) dac_writes++;
            if (got.wr !== want.wr || got.value !== want.value || got.mode !== want.mode ||
                got.accepted !== want.accepted || got.fill !== want.fill) begin
               err_count++;
               if (err_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch exp wr %0b value %h mode %0d acc %0b fill %0d",
                           $realtime, want.wr, want.value, want.mode, want.accepted,
                           want.fill);
                  $display("%0t:          got wr %0b value %h mode %0d acc %0b fill %0d",
                           $realtime, got.wr, got.value, got.mode, got.accepted, got.fill);
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      foreach (pl_store[i]) pl_store[i] = '0;

      // after reset, default threshold
      dir_rows.push_back(known_row(adpf_pkg::CMD_TICK,  8'h00, 1'b1, 12'h000,
                                   adpf_pkg::MODE_STOPPED, 1'b0, 9'd0));
      dir_rows.push_back(known_row(adpf_pkg::CMD_STOP,  8'h00, 1'b0, 12'h000,
                                   adpf_pkg::MODE_STOPPED, 1'b0, 9'd0));
      dir_rows.push_back(known_row(adpf_pkg::CMD_PUSH,  8'hFF, 1'b0, 12'h000,
                                   adpf_pkg::MODE_STOPPED, 1'b1, 9'd1));
      dir_rows.push_back(known_row(adpf_pkg::CMD_TICK,  8'h00, 1'b1, 12'h000,
                                   adpf_pkg::MODE_STOPPED, 1'b0, 9'd1));
      dir_rows.push_back(known_row(adpf_pkg::CMD_START, 8'hFF, 1'b0, 12'h000,
                                   adpf_pkg::MODE_STARTING, 1'b0, 9'd0));
      dir_rows.push_back(known_row(adpf_pkg::CMD_TICK,  8'h00, 1'b1, 12'h000,
                                   adpf_pkg::MODE_STARTING, 1'b0, 9'd0));
      // smallest usable threshold: play full scale and zero, then underrun
      dir_rows.push_back(cfg_row(9'd1));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_PUSH, 8'hFF));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_PUSH, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_PUSH, 8'hA5));
      dir_rows.push_back(known_row(adpf_pkg::CMD_TICK,  8'h00, 1'b0, 12'h000,
                                   adpf_pkg::MODE_PLAYING, 1'b0, 9'd3));
      dir_rows.push_back(known_row(adpf_pkg::CMD_TICK,  8'h00, 1'b1, 12'hFF0,
                                   adpf_pkg::MODE_PLAYING, 1'b0, 9'd2));
      dir_rows.push_back(known_row(adpf_pkg::CMD_TICK,  8'hFF, 1'b1, 12'h000,
                                   adpf_pkg::MODE_PLAYING, 1'b0, 9'd1));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));
      // resume, then stop from playing and again while stopping
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_PUSH, 8'h80));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_STOP, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_STOP, 8'h00));
      // zero threshold plays at once; stop from a zero level
      dir_rows.push_back(cfg_row(9'd0));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_START, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_STOP, 8'h00));
      dir_rows.push_back(cmd_row(adpf_pkg::CMD_TICK, 8'h00));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg)
            write_threshold(dir_rows[i].cfg_val);
         else
            send_item(dir_rows[i].cmd, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].res);
      end

      // small threshold, lots of playing and underruns
      write_threshold(adpf_pkg::THRESH_W'($urandom_range(2, 8)));
      run_session(90, 45);

      // reset value of the threshold
      write_threshold(adpf_pkg::THRESH_RESET);
      run_session(50, 55);

      // fill the store past full while the response side holds off
      write_threshold(9'd256);
      hold_off_req = 1'b1;
      send_item(adpf_pkg::CMD_START, 8'($urandom));
      repeat (FIFO_DEPTH + 2) send_item(adpf_pkg::CMD_PUSH, 8'($urandom));
      repeat (8) send_item(adpf_pkg::CMD_TICK, 8'($urandom));
      repeat (3) send_item(adpf_pkg::CMD_PUSH, 8'($urandom));
      send_item(adpf_pkg::CMD_STOP, 8'($urandom));
      repeat (20) send_item(adpf_pkg::CMD_TICK, 8'($urandom));

      // threshold that can never be reached
      write_threshold(9'd511);
      run_session(40, 50);

      // last part without any idling
      write_threshold(adpf_pkg::THRESH_W'($urandom_range(1, 16)));
      no_idle = 1'b1;
      run_session(40, 45);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("%0d commands, %0d responses checked, %0d converter writes, %0d refused pushes",
               items_sent, rsp_checked, dac_writes, refused_pushes);
      $display("thresholds 0, 1, small, 128, 256 and 511 with long response hold-off and drains");
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
sv/adpf_pkg.sv
sv/adpf_ram.sv
sv/adpf_front.sv
sv/adpf_back.sv
sv/audio_dac_playback_fader.sv
dv/audio_dac_playback_fader_tb.sv
